@@ rtl/core/ring_router_shortest_direction_core_macros.svh @@
// Assertion macros for the ring router core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef RING_ROUTER_SHORTEST_DIRECTION_CORE_MACROS_SVH
`define RING_ROUTER_SHORTEST_DIRECTION_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted (active low).
`define RRSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ring router assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define RRSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ring router assertion failed");

`else

`define RRSD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RRSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/rrsd_pkg.sv @@
// Shared types, codes and helpers for the ring router core.
// No dependencies; imported by ring_router_shortest_direction_core.
`default_nettype none

package rrsd_pkg;

    // Word widths on the stream ports.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // Field widths.
    localparam int NODE_W = 6;
    localparam int HOPS_W = 8;
    localparam int RING_W = 7;
    localparam int DIST_W = 6;

    // Saturation limits.
    localparam logic [HOPS_W-1:0] HOPS_MAX  = 8'd255;
    localparam logic [RING_W-1:0] RING_MAX  = 7'd127;
    localparam logic [RING_W-1:0] ECHO_MAX  = 7'd127;
    localparam logic [DIST_W-1:0] DIST_MAX  = 6'd63;

    // Input word kinds.
    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_HELLO = 2'd1,
        MODE_ECHO  = 2'd2,
        MODE_DATA  = 2'd3
    } mode_t;

    // Port codes, shared by arrival and departure.
    localparam logic [1:0] PORT_APP = 2'd0;
    localparam logic [1:0] PORT_L0  = 2'd1;
    localparam logic [1:0] PORT_L1  = 2'd2;

    // Result word kinds.
    localparam logic [1:0] KIND_HELLO = 2'd0;
    localparam logic [1:0] KIND_ECHO  = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    // One result word as held in the output register.
    typedef struct packed {
        logic              last;
        logic [1:0]        kind;
        logic [HOPS_W-1:0] hops;
        logic [NODE_W-1:0] dst;
        logic [NODE_W-1:0] src;
        logic [1:0]        port;
    } out_word_t;

    // Hop increment that sticks at the top value.
    function automatic logic [HOPS_W-1:0] sat_inc(input logic [HOPS_W-1:0] h);
        logic [HOPS_W-1:0] r;
        r = (h == HOPS_MAX) ? HOPS_MAX : h + 8'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rrsd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the distance table.
`default_nettype none

module rrsd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64
) (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [DATA_W-1:0]          wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [DATA_W-1:0]          rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while re is low.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/ring_router_shortest_direction_core.sv @@
// Ring node router: discovery, echo collection and shortest-direction data routing.
// Depends on rrsd_pkg, rrsd_ram and ring_router_shortest_direction_core_macros.svh.
//
//  Channel   Direction  Handshake           Contents
//  s_        in         s_tvalid/s_tready   one packet word (mode in s_tuser)
//  m_        out        m_tvalid/m_tready   one result word (kind in m_tuser, last in m_tlast)
//  cfg_      in         cfg_we              own node index
//
// A word is taken into the stage register, with the distance table read at the
// same edge; its results come from short logic into the output register.
// Most words leave the stage with their one result word; a forwarded hello leaves
// after its second, and a word with no result frees the stage at once.
// Reset is synchronous and active low; the distance table is not cleared.
// A full output register that is not taken holds the stage and then s_tready.
`default_nettype none

module ring_router_shortest_direction_core
    import rrsd_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // Configuration.
    input  wire logic                 cfg_we,
    input  wire logic [NODE_W-1:0]    cfg_wdata,

    // Input words.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [1:0] arrival_port, [7:2] source, [13:8] destination, [21:14] hop_count, [23:22] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] mode
    input  wire logic [1:0]           s_tuser,

    // Result words.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [1:0] out_port, [7:2] out_source, [13:8] out_destination, [21:14] out_hops, [23:22] zero
    output logic [M_TDATA_W-1:0]      m_tdata,
    // [1:0] kind
    output logic [1:0]                m_tuser,
    output logic                      m_tlast
);

`include "ring_router_shortest_direction_core_macros.svh"

    localparam int ADDR_W = $clog2(MAX_NODES);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [NODE_W-1:0] own_index_reg;
    logic [RING_W-1:0] ring_size_reg, ring_size_next;
    logic [RING_W-1:0] echo_count_reg, echo_count_next;

    logic              st_valid_reg, st_valid_next;
    logic              st_phase_reg, st_phase_next;
    mode_t             st_mode_reg;
    logic [1:0]        st_port_reg;
    logic [NODE_W-1:0] st_src_reg;
    logic [NODE_W-1:0] st_dst_reg;
    logic [HOPS_W-1:0] st_hops_reg;
    logic              st_dst_ok_reg;

    logic              m_valid_reg, m_valid_next;
    out_word_t         m_word_reg;

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    mode_t             in_mode;
    logic [1:0]        in_port;
    logic [NODE_W-1:0] in_src;
    logic [NODE_W-1:0] in_dst;
    logic [HOPS_W-1:0] in_hops;
    logic              in_acc;
    logic              in_dst_own;
    logic              in_src_ok;
    logic              in_dst_ok;

    assign in_mode    = mode_t'(s_tuser);
    assign in_port    = s_tdata[1:0];
    assign in_src     = s_tdata[7:2];
    assign in_dst     = s_tdata[13:8];
    assign in_hops    = s_tdata[21:14];
    assign in_acc     = s_tvalid && s_tready;
    assign in_dst_own = (in_dst == own_index_reg);
    assign in_src_ok  = (32'(in_src) < 32'(MAX_NODES));
    assign in_dst_ok  = (32'(in_dst) < 32'(MAX_NODES));

    // ------------------------------------------------------------------
    // Distance table: written by echoes for this node, read for every word
    // ------------------------------------------------------------------
    logic              tbl_we;
    logic [DIST_W-1:0] tbl_wdata;
    logic [DIST_W-1:0] tbl_rdata;

    assign tbl_we    = in_acc && (in_mode == MODE_ECHO) && in_dst_own && in_src_ok;
    assign tbl_wdata = (in_hops > 8'(DIST_MAX)) ? DIST_MAX : in_hops[DIST_W-1:0];

    rrsd_ram #(
        .DATA_W (DIST_W),
        .DEPTH  (MAX_NODES)
    ) u_dist_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (ADDR_W'(in_src)),
        .wdata (tbl_wdata),
        .re    (in_acc),
        .raddr (ADDR_W'(in_dst)),
        .rdata (tbl_rdata)
    );

    // ------------------------------------------------------------------
    // Ring size and echo count update at acceptance
    // ------------------------------------------------------------------
    logic [HOPS_W:0] ring_cand;

    assign ring_cand = {1'b0, in_hops} + 9'd1;

    always_comb begin
        ring_size_next  = ring_size_reg;
        echo_count_next = echo_count_reg;
        if (in_acc && in_dst_own) begin
            if (in_mode == MODE_HELLO) begin
                ring_size_next = (ring_cand > 9'(RING_MAX)) ? RING_MAX
                                                            : ring_cand[RING_W-1:0];
            end
            if (in_mode == MODE_ECHO && echo_count_reg != ECHO_MAX) begin
                echo_count_next = echo_count_reg + 7'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result word for the item in the stage
    // ------------------------------------------------------------------
    logic              st_dst_own;
    logic              st_emit;
    logic              st_final;
    logic              tbl_complete;
    logic [DIST_W-1:0] st_dist;
    logic [HOPS_W-1:0] st_hops_inc;
    out_word_t         st_word;

    assign st_dst_own   = (st_dst_reg == own_index_reg);
    assign st_hops_inc  = sat_inc(st_hops_reg);
    assign st_dist      = st_dst_ok_reg ? tbl_rdata : '0;
    assign tbl_complete = (ring_size_reg != '0)
                       && ((8'(echo_count_reg) + 8'd1) >= 8'(ring_size_reg));

    always_comb begin
        st_emit  = 1'b1;
        st_final = 1'b1;
        st_word  = '{last: 1'b1, kind: KIND_DATA, hops: st_hops_reg,
                     dst: st_dst_reg, src: st_src_reg, port: PORT_L0};
        case (st_mode_reg)
            MODE_START: begin
                st_word.kind = KIND_HELLO;
                st_word.src  = own_index_reg;
                st_word.dst  = own_index_reg;
                st_word.hops = '0;
            end
            MODE_HELLO: begin
                if (st_dst_own) begin
                    // Returned hello: ring size already taken, nothing sent.
                    st_emit = 1'b0;
                end else if (!st_phase_reg) begin
                    // Forward the hello first.
                    st_final     = 1'b0;
                    st_word.last = 1'b0;
                    st_word.kind = KIND_HELLO;
                    st_word.hops = st_hops_inc;
                end else begin
                    // Then echo the distance back toward its origin.
                    st_word.kind = KIND_ECHO;
                    st_word.port = PORT_L1;
                    st_word.src  = own_index_reg;
                    st_word.dst  = st_src_reg;
                    st_word.hops = st_hops_inc;
                end
            end
            MODE_ECHO: begin
                if (st_dst_own) begin
                    st_emit = 1'b0;
                end else begin
                    st_word.kind = KIND_ECHO;
                    st_word.port = (st_port_reg == PORT_L0) ? PORT_L1 : PORT_L0;
                end
            end
            MODE_DATA: begin
                if (st_dst_own) begin
                    st_word.port = PORT_APP;
                    st_word.hops = st_hops_inc;
                end else if (st_port_reg == PORT_APP) begin
                    // Local data: pick the shorter way once the table is full.
                    if (tbl_complete && (7'(st_dist) > (ring_size_reg >> 1))) begin
                        st_word.port = PORT_L1;
                    end
                end else begin
                    st_word.port = (st_port_reg == PORT_L0) ? PORT_L1 : PORT_L0;
                    st_word.hops = st_hops_inc;
                end
            end
            default: begin
                st_emit = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stage and output handshake
    // ------------------------------------------------------------------
    logic out_free;
    logic st_step;
    logic st_done;
    logic out_load;

    assign out_free = !m_valid_reg || m_tready;
    assign st_step  = st_valid_reg && (!st_emit || out_free);
    assign st_done  = st_step && st_final;
    assign out_load = st_valid_reg && st_emit && out_free;
    assign s_tready = !st_valid_reg || st_done;

    always_comb begin
        st_valid_next = st_valid_reg;
        st_phase_next = st_phase_reg;
        if (in_acc) begin
            st_valid_next = 1'b1;
            st_phase_next = 1'b0;
        end else if (st_done) begin
            st_valid_next = 1'b0;
            st_phase_next = 1'b0;
        end else if (st_step) begin
            st_phase_next = 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_index_reg  <= '0;
            ring_size_reg  <= '0;
            echo_count_reg <= '0;
            st_valid_reg   <= 1'b0;
            st_phase_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                own_index_reg <= cfg_wdata;
            end
            ring_size_reg  <= ring_size_next;
            echo_count_reg <= echo_count_next;
            st_valid_reg   <= st_valid_next;
            st_phase_reg   <= st_phase_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            st_mode_reg   <= in_mode;
            st_port_reg   <= in_port;
            st_src_reg    <= in_src;
            st_dst_reg    <= in_dst;
            st_hops_reg   <= in_hops;
            st_dst_ok_reg <= in_dst_ok;
        end
        if (out_load) begin
            m_word_reg <= st_word;
        end
    end

    // Output packing.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_word_reg.hops, m_word_reg.dst, m_word_reg.src,
                       m_word_reg.port};
    assign m_tuser  = m_word_reg.kind;
    assign m_tlast  = m_word_reg.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RRSD_ASSERT_IMPL(a_empty_stage_ready, aclk, aresetn, !st_valid_reg, s_tready)

    `RRSD_ASSERT_IMPL(a_phase_only_hello, aclk, aresetn, st_phase_reg,
        st_valid_reg && st_mode_reg == MODE_HELLO && !st_dst_own)

    `RRSD_ASSERT_IMPL(a_first_of_two_is_hello, aclk, aresetn, m_valid_reg && !m_word_reg.last,
        m_word_reg.kind == KIND_HELLO && m_word_reg.port == PORT_L0)

    `RRSD_ASSERT_NEXT(a_echo_counted, aclk, aresetn,
        in_acc && in_mode == MODE_ECHO && in_dst_own && echo_count_reg != ECHO_MAX,
        echo_count_reg == $past(echo_count_reg) + 7'd1)

endmodule

`default_nettype wire
